[rtl/core/gls_pkg.sv]
// Shared types and constants for the grid line-of-sight block.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package gls_pkg;

  // Field widths of the stream payloads.
  localparam int AXIS_W     = 8;   // one grid coordinate as it arrives
  localparam int COORD_W    = 10;  // signed probe coordinate, covers -1 .. 256
  localparam int ERR_W      = 9;   // error accumulator, stays below twice the major delta
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // Item kinds carried in in_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CUT_CORNERS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_SQUEEZE = 1'b1;

  // Which neighbor cell the datapath reads for the current test.
  typedef logic [2:0] probe_t;
  localparam probe_t PRB_STEP   = 3'd0;  // major+offset, minor+offset
  localparam probe_t PRB_SIDE0  = 3'd1;  // major+offset, minor
  localparam probe_t PRB_SIDE1  = 3'd2;  // major+offset, minor-1
  localparam probe_t PRB_DIAG   = 3'd3;  // one step along both axes
  localparam probe_t PRB_DIAG_B = 3'd4;  // one step along the minor axis only
  localparam probe_t PRB_DIAG_A = 3'd5;  // one step along the major axis only

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;        // capture a query's end points
    logic   acc_err;     // add the minor delta to the error term
    logic   take_carry;  // step the minor axis and take the major delta off
    logic   advance;     // step the major axis
    logic   rd_en;       // read the probe cell
    probe_t probe;
    logic   wr_cell;     // write the cell of the accepted write item
    logic   clr_step;    // clear one grid cell and step the sweep counter
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // last probe cell is blocked or off the grid
    logic done;        // major coordinate has reached the end point
    logic carry;       // error term reached the major delta
    logic err_zero;
    logic minor_zero;  // the line is parallel to the major axis
    logic diag;        // both deltas are equal
    logic clr_last;    // clearing sweep is at its last cell
  } dp_sts_t;

endpackage

[rtl/core/gls_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gls_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/gls_datapath.sv]
// Datapath of the line-of-sight block: walk coordinates, error term, probe
// addressing, out-of-grid test and the occupancy RAM. Uses gls_pkg and gls_ram.
module gls_datapath #(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gls_pkg::dp_cmd_t           cmd,
  output gls_pkg::dp_sts_t           sts,
  input  logic [gls_pkg::AXIS_W-1:0] cell_row,
  input  logic [gls_pkg::AXIS_W-1:0] cell_col,
  input  logic                       cell_blocked,
  input  logic [gls_pkg::AXIS_W-1:0] from_row,
  input  logic [gls_pkg::AXIS_W-1:0] from_col,
  input  logic [gls_pkg::AXIS_W-1:0] to_row,
  input  logic [gls_pkg::AXIS_W-1:0] to_col
);

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = gls_pkg::AXIS_W;
  localparam int CW    = gls_pkg::COORD_W;
  localparam int EW    = gls_pkg::ERR_W;

  // Walk state. The major axis is the one with the larger delta, the row axis on a tie.
  logic [XW-1:0] a_r, a_nxt;
  logic [XW-1:0] b_r, b_nxt;
  logic [XW-1:0] a_end_r, a_end_nxt;
  logic [XW-1:0] dmaj_r, dmaj_nxt;
  logic [XW-1:0] dmin_r, dmin_nxt;
  logic [EW-1:0] err_r, err_nxt;
  logic          neg_a_r, neg_a_nxt;
  logic          neg_b_r, neg_b_nxt;
  logic          swap_r, swap_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          oob_r, oob_nxt;

  // Deltas and directions of an incoming query.
  logic          row_neg, col_neg, in_swap;
  logic [XW-1:0] drow, dcol;

  assign row_neg = to_row < from_row;
  assign col_neg = to_col < from_col;
  assign drow    = row_neg ? (from_row - to_row) : (to_row - from_row);
  assign dcol    = col_neg ? (from_col - to_col) : (to_col - from_col);
  assign in_swap = drow < dcol;

  // Next state of the walk registers.
  always_comb begin
    a_nxt       = a_r;
    b_nxt       = b_r;
    a_end_nxt   = a_end_r;
    dmaj_nxt    = dmaj_r;
    dmin_nxt    = dmin_r;
    err_nxt     = err_r;
    neg_a_nxt   = neg_a_r;
    neg_b_nxt   = neg_b_r;
    swap_nxt    = swap_r;
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.load) begin
      swap_nxt  = in_swap;
      a_nxt     = in_swap ? from_col : from_row;
      b_nxt     = in_swap ? from_row : from_col;
      a_end_nxt = in_swap ? to_col : to_row;
      dmaj_nxt  = in_swap ? dcol : drow;
      dmin_nxt  = in_swap ? drow : dcol;
      neg_a_nxt = in_swap ? col_neg : row_neg;
      neg_b_nxt = in_swap ? row_neg : col_neg;
      err_nxt   = '0;
    end
    if (cmd.acc_err) begin
      err_nxt = err_r + {1'b0, dmin_r};
    end
    if (cmd.take_carry) begin
      b_nxt   = neg_b_r ? (b_r - 1'b1) : (b_r + 1'b1);
      err_nxt = err_r - {1'b0, dmaj_r};
    end
    if (cmd.advance) begin
      a_nxt = neg_a_r ? (a_r - 1'b1) : (a_r + 1'b1);
    end
    if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    a_end_r <= a_end_nxt;
    dmaj_r  <= dmaj_nxt;
    dmin_r  <= dmin_nxt;
    err_r   <= err_nxt;
    neg_a_r <= neg_a_nxt;
    neg_b_r <= neg_b_nxt;
    swap_r  <= swap_nxt;
    oob_r   <= oob_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Probe cell in major/minor terms, then mapped back to row and column.
  logic [CW-1:0] ae, be, step_a, step_b, off_a, off_b, pa, pb;
  logic [CW-1:0] p_row, p_col;
  logic          row_ok, col_ok;

  assign ae     = {{(CW-XW){1'b0}}, a_r};
  assign be     = {{(CW-XW){1'b0}}, b_r};
  assign step_a = neg_a_r ? {CW{1'b1}} : CW'(1);
  assign step_b = neg_b_r ? {CW{1'b1}} : CW'(1);
  assign off_a  = neg_a_r ? {CW{1'b1}} : '0;
  assign off_b  = neg_b_r ? {CW{1'b1}} : '0;

  always_comb begin
    case (cmd.probe)
      gls_pkg::PRB_STEP: begin
        pa = ae + off_a;
        pb = be + off_b;
      end
      gls_pkg::PRB_SIDE0: begin
        pa = ae + off_a;
        pb = be;
      end
      gls_pkg::PRB_SIDE1: begin
        pa = ae + off_a;
        pb = be - CW'(1);
      end
      gls_pkg::PRB_DIAG: begin
        pa = ae + step_a;
        pb = be + step_b;
      end
      gls_pkg::PRB_DIAG_B: begin
        pa = ae;
        pb = be + step_b;
      end
      gls_pkg::PRB_DIAG_A: begin
        pa = ae + step_a;
        pb = be;
      end
      default: begin
        pa = ae;
        pb = be;
      end
    endcase
  end

  assign p_row  = swap_r ? pb : pa;
  assign p_col  = swap_r ? pa : pb;
  assign row_ok = !p_row[CW-1] && (32'(p_row[CW-2:0]) < GRID_ROWS);
  assign col_ok = !p_col[CW-1] && (32'(p_col[CW-2:0]) < GRID_COLS);

  // Cells off the grid read as blocked; the flag travels with the read.
  assign oob_nxt = cmd.rd_en ? !(row_ok && col_ok) : oob_r;

  // RAM addressing for reads, cell writes and the clearing sweep.
  logic [AW-1:0] rd_addr, cell_addr, wr_addr;
  logic          cell_ok, wr_en, wr_bit, rd_bit;

  assign rd_addr   = AW'(32'(p_row[CW-2:0]) * GRID_COLS + 32'(p_col[CW-2:0]));
  assign cell_addr = AW'(32'(cell_row) * GRID_COLS + 32'(cell_col));
  assign cell_ok   = (32'(cell_row) < GRID_ROWS) && (32'(cell_col) < GRID_COLS);
  assign wr_en     = cmd.clr_step || (cmd.wr_cell && cell_ok);
  assign wr_addr   = cmd.clr_step ? clr_cnt_r : cell_addr;
  assign wr_bit    = cmd.clr_step ? 1'b0 : cell_blocked;

  gls_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_bit),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_bit)
  );

  // Status back to the controller.
  assign sts.hit        = oob_r || rd_bit;
  assign sts.done       = a_r == a_end_r;
  assign sts.carry      = err_r >= {1'b0, dmaj_r};
  assign sts.err_zero   = err_r == '0;
  assign sts.minor_zero = dmin_r == '0;
  assign sts.diag       = dmaj_r == dmin_r;
  assign sts.clr_last   = clr_cnt_r == AW'(DEPTH - 1);

endmodule

[rtl/core/gls_ctrl.sv]
// Controller of the line-of-sight block: sequencer for clearing, writes and the
// line walk, the configuration registers and the result register. Uses gls_pkg.
module gls_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_cmd,
  output logic                                in_ready,
  output logic                                out_valid,
  output logic                                out_clear,
  input  logic                                out_ready,
  input  logic                                cfg_we,
  input  logic [gls_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic                                cfg_wdata,
  output gls_pkg::dp_cmd_t                    cmd,
  input  gls_pkg::dp_sts_t                    sts
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLEAR  = 4'd1;
  localparam logic [3:0] ST_DECIDE = 4'd2;
  localparam logic [3:0] ST_LOOP   = 4'd3;
  localparam logic [3:0] ST_CARRY  = 4'd4;
  localparam logic [3:0] ST_CHK1   = 4'd5;
  localparam logic [3:0] ST_MID    = 4'd6;
  localparam logic [3:0] ST_CHK2   = 4'd7;
  localparam logic [3:0] ST_SIDE   = 4'd8;
  localparam logic [3:0] ST_CHK3   = 4'd9;
  localparam logic [3:0] ST_CHK4   = 4'd10;
  localparam logic [3:0] ST_DCHK1  = 4'd11;
  localparam logic [3:0] ST_DCHK2  = 4'd12;
  localparam logic [3:0] ST_DCHK3  = 4'd13;
  localparam logic [3:0] ST_FIN    = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_clear_r, out_clear_nxt;
  logic       cut_r, cut_nxt;
  logic       squeeze_r, squeeze_nxt;
  logic       in_fire, mid_test;

  assign in_ready  = state_r == ST_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_clear = out_clear_r;

  // The relaxed test probes when the error term is off zero, the strict one on zero.
  assign mid_test = cut_r ? !sts.err_zero : sts.err_zero;

  // Configuration registers.
  always_comb begin
    cut_nxt     = cut_r;
    squeeze_nxt = squeeze_r;
    if (cfg_we) begin
      case (cfg_idx)
        gls_pkg::REG_CUT_CORNERS:   cut_nxt     = cfg_wdata;
        gls_pkg::REG_ALLOW_SQUEEZE: squeeze_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_clear_nxt = out_clear_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == gls_pkg::CMD_QUERY) begin
            cmd.load  = 1'b1;
            state_nxt = ST_DECIDE;
          end else begin
            cmd.wr_cell = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DECIDE: begin
        if (cut_r && sts.diag) begin
          if (squeeze_r) begin
            cmd.rd_en = 1'b1;
            cmd.probe = gls_pkg::PRB_DIAG;
            state_nxt = ST_DCHK1;
          end else begin
            res_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.done) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cmd.acc_err = 1'b1;
          state_nxt   = ST_CARRY;
        end
      end
      ST_CARRY: begin
        if (sts.carry) begin
          cmd.rd_en = 1'b1;
          cmd.probe = gls_pkg::PRB_STEP;
          state_nxt = ST_CHK1;
        end else begin
          state_nxt = ST_MID;
        end
      end
      ST_CHK1: begin
        if (sts.hit) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          cmd.take_carry = 1'b1;
          state_nxt      = ST_MID;
        end
      end
      ST_MID: begin
        if (mid_test) begin
          cmd.rd_en = 1'b1;
          cmd.probe = gls_pkg::PRB_STEP;
          state_nxt = ST_CHK2;
        end else begin
          state_nxt = ST_SIDE;
        end
      end
      ST_CHK2: begin
        if (sts.hit) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        if (sts.minor_zero) begin
          cmd.rd_en = 1'b1;
          cmd.probe = gls_pkg::PRB_SIDE0;
          state_nxt = ST_CHK3;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_LOOP;
        end
      end
      ST_CHK3: begin
        // An axis-parallel line is blocked only when both side cells are.
        if (sts.hit) begin
          cmd.rd_en = 1'b1;
          cmd.probe = gls_pkg::PRB_SIDE1;
          state_nxt = ST_CHK4;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_LOOP;
        end
      end
      ST_CHK4: begin
        if (sts.hit) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_LOOP;
        end
      end
      ST_DCHK1: begin
        if (sts.hit) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.probe = gls_pkg::PRB_DIAG_B;
          state_nxt = ST_DCHK2;
        end
      end
      ST_DCHK2: begin
        // The diagonal squeezes through unless both flanking cells are blocked.
        if (sts.hit) begin
          cmd.rd_en = 1'b1;
          cmd.probe = gls_pkg::PRB_DIAG_A;
          state_nxt = ST_DCHK3;
        end else begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_DCHK3: begin
        res_nxt   = !sts.hit;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_clear_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      cut_r       <= 1'b1;
      squeeze_r   <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cut_r       <= cut_nxt;
      squeeze_r   <= squeeze_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    out_clear_r <= out_clear_nxt;
  end

endmodule

[rtl/core/grid_line_of_sight.sv]
// Top level of the grid line-of-sight block: stream ports, controller and datapath.
// Depends on gls_pkg, gls_ctrl, gls_datapath (and through it gls_ram).
//
//  Channel  Direction  Handshake         Payload
//  in_      slave      tvalid / tready   tuser: cmd; tdata: cell and query fields
//  out_     master     tvalid / tready   tdata: line_clear
//  cfg_     write      cfg_we            cfg_idx, cfg_wdata
//
// After reset the grid is swept clear, one cell per cycle over all GRID_ROWS * GRID_COLS
// cells (65536 at the defaults), while in_tready stays low.
// A write item is written to the grid RAM as it is accepted, and the block stays ready.
// A query walks the line one step at a time along the longer axis, testing one cell
// at a time through the single read port of the grid RAM.
// A new item is taken while a result still waits in the output register; a
// query only waits at its end if that register is still full.
module grid_line_of_sight #(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,   // [0] cmd
  // [7:0] cell_row, [15:8] cell_col, [16] cell_blocked, [24:17] from_row,
  // [32:25] from_col, [40:33] to_row, [48:41] to_col, [55:49] zero
  input  logic [gls_pkg::IN_DATA_W-1:0]   in_tdata,
  // Results.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gls_pkg::OUT_DATA_W-1:0]  out_tdata,  // [0] line_clear, [7:1] zero
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [gls_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic                            cfg_wdata
);

  gls_pkg::dp_cmd_t dp_cmd;
  gls_pkg::dp_sts_t dp_sts;
  logic             out_clear;

  gls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_clear (out_clear),
    .out_ready (out_tready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  gls_datapath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .cell_row     (in_tdata[7:0]),
    .cell_col     (in_tdata[15:8]),
    .cell_blocked (in_tdata[16]),
    .from_row     (in_tdata[24:17]),
    .from_col     (in_tdata[32:25]),
    .to_row       (in_tdata[40:33]),
    .to_col       (in_tdata[48:41])
  );

  assign out_tdata = {{(gls_pkg::OUT_DATA_W-1){1'b0}}, out_clear};

endmodule

[rtl/core/gls_checker.sv]
// Port-level checks for the grid line-of-sight block, bound to the top level.
// Depends on gls_pkg and grid_line_of_sight.
module gls_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gls_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Reset starts the clearing sweep, so no item is taken right after it.
  assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready while the grid is being cleared");

  // A query keeps the block busy for at least the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == gls_pkg::CMD_QUERY) |=> !in_tready)
    else $error("input taken right after a query transfer");

  // After a cell write the block is ready again in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == gls_pkg::CMD_WRITE) |=> in_tready)
    else $error("block not ready after a cell write");

  // The padding bits of a result are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[gls_pkg::OUT_DATA_W-1:1] == '0)
    else $error("result padding bits set");

endmodule

bind grid_line_of_sight gls_checker u_gls_checker (.*);
